// File: design/kcv3d_pkg.sv
// Shared types, constants and the step program of the constant-velocity tracker.
package kcv3d_pkg;

	localparam int Axes = 3;
	localparam int TimeFracBits = 20;
	localparam int DtsShift = TimeFracBits - 16;

	localparam logic [63:0] CovCap = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MagCap = 64'h4000_0000_0000_0000;
	localparam logic [63:0] MaxCap = 64'hFFFF_FFFF_FFFF_FFFF;

	// pos_init_std^2 and vel_init_std^2 at their reset values, Q8
	localparam logic [63:0] CovPosRst = 64'd256000000;
	localparam logic [63:0] CovVelRst = 64'd64000000;

	localparam logic signed [63:0] P48Max = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] P48Min = -64'sh0000_8000_0000_0000;
	localparam logic signed [63:0] P32Max = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] P32Min = -64'sh0000_0000_8000_0000;

	localparam logic [2:0] CfgAccel = 3'd0;
	localparam logic [2:0] CfgSigmaMin = 3'd1;
	localparam logic [2:0] CfgSigmaMax = 3'd2;

	localparam logic [1:0] KindPredicted = 2'd0;
	localparam logic [1:0] KindApplied = 2'd1;
	localparam logic [1:0] KindIgnored = 2'd2;
	localparam logic [1:0] KindNotAhead = 2'd3;

	localparam logic [4:0] StepMeas = 5'd0;
	localparam logic [4:0] StepQuery = 5'd23;

	typedef enum logic [1:0] {CAP_MAX, CAP_COV, CAP_MAG} cap_t;

	typedef enum logic [3:0] {
		A_VEL, A_DTS, A_ACC, A_Q, A_CC, A_CV, A_QDT2, A_CP, A_SIG, A_Y
	} asel_t;

	typedef enum logic [2:0] {B_DT, B_DTS, B_ACC, B_DT2, B_K1, B_K2, B_SIG} bsel_t;

	typedef enum logic [3:0] {
		ACT_POS, ACT_VEL, ACT_RES, ACT_DT2, ACT_Q, ACT_QDT2, ACT_NP0, ACT_NP,
		ACT_NC0, ACT_NCC, ACT_S, ACT_K1, ACT_K2, ACT_DV, ACT_CP, ACT_CC
	} act_t;

	typedef struct packed {
		asel_t      asel;
		bsel_t      bsel;
		logic [5:0] shift;
		cap_t       cap;
		act_t       act;
		logic [1:0] axis;
		logic       is_div;
		logic       last;
	} ucode_t;

	function automatic ucode_t mk(input asel_t a, input bsel_t b, input logic [5:0] sh,
			input cap_t c, input act_t act, input logic [1:0] axis, input logic dv,
			input logic last);
		ucode_t u;
		u.asel = a;
		u.bsel = b;
		u.shift = sh;
		u.cap = c;
		u.act = act;
		u.axis = axis;
		u.is_div = dv;
		u.last = last;
		return u;
	endfunction

	// Step program: predict (0..10), update (11..22), query extrapolation (23..25)
	function automatic ucode_t ucode(input logic [4:0] step);
		ucode_t u;
		case (step)
			5'd0:  u = mk(A_VEL, B_DT, 6'(TimeFracBits), CAP_MAG, ACT_POS, 2'd0, 1'b0, 1'b0);
			5'd1:  u = mk(A_VEL, B_DT, 6'(TimeFracBits), CAP_MAG, ACT_POS, 2'd1, 1'b0, 1'b0);
			5'd2:  u = mk(A_VEL, B_DT, 6'(TimeFracBits), CAP_MAG, ACT_POS, 2'd2, 1'b0, 1'b0);
			5'd3:  u = mk(A_DTS, B_DTS, 6'd16, CAP_MAX, ACT_DT2, 2'd0, 1'b0, 1'b0);
			5'd4:  u = mk(A_ACC, B_ACC, 6'd0, CAP_MAX, ACT_Q, 2'd0, 1'b0, 1'b0);
			5'd5:  u = mk(A_Q, B_DT2, 6'd8, CAP_MAX, ACT_QDT2, 2'd0, 1'b0, 1'b0);
			5'd6:  u = mk(A_CC, B_DTS, 6'd15, CAP_COV, ACT_NP0, 2'd0, 1'b0, 1'b0);
			5'd7:  u = mk(A_CV, B_DT2, 6'd16, CAP_COV, ACT_NP, 2'd0, 1'b0, 1'b0);
			5'd8:  u = mk(A_QDT2, B_DT2, 6'd18, CAP_COV, ACT_NP, 2'd0, 1'b0, 1'b0);
			5'd9:  u = mk(A_CV, B_DTS, 6'd16, CAP_COV, ACT_NC0, 2'd0, 1'b0, 1'b0);
			5'd10: u = mk(A_QDT2, B_DTS, 6'd17, CAP_COV, ACT_NCC, 2'd0, 1'b0, 1'b0);
			5'd11: u = mk(A_SIG, B_SIG, 6'd24, CAP_MAX, ACT_S, 2'd0, 1'b0, 1'b0);
			5'd12: u = mk(A_CP, B_K1, 6'd0, CAP_MAX, ACT_K1, 2'd0, 1'b1, 1'b0);
			5'd13: u = mk(A_CC, B_K2, 6'd0, CAP_MAX, ACT_K2, 2'd0, 1'b1, 1'b0);
			5'd14: u = mk(A_Y, B_K2, 6'd32, CAP_MAG, ACT_VEL, 2'd0, 1'b0, 1'b0);
			5'd15: u = mk(A_Y, B_K1, 6'd32, CAP_MAG, ACT_POS, 2'd0, 1'b0, 1'b0);
			5'd16: u = mk(A_Y, B_K2, 6'd32, CAP_MAG, ACT_VEL, 2'd1, 1'b0, 1'b0);
			5'd17: u = mk(A_Y, B_K1, 6'd32, CAP_MAG, ACT_POS, 2'd1, 1'b0, 1'b0);
			5'd18: u = mk(A_Y, B_K2, 6'd32, CAP_MAG, ACT_VEL, 2'd2, 1'b0, 1'b0);
			5'd19: u = mk(A_Y, B_K1, 6'd32, CAP_MAG, ACT_POS, 2'd2, 1'b0, 1'b0);
			5'd20: u = mk(A_CC, B_K2, 6'd32, CAP_COV, ACT_DV, 2'd0, 1'b0, 1'b0);
			5'd21: u = mk(A_CP, B_K1, 6'd32, CAP_COV, ACT_CP, 2'd0, 1'b0, 1'b0);
			5'd22: u = mk(A_CC, B_K1, 6'd32, CAP_COV, ACT_CC, 2'd0, 1'b0, 1'b1);
			5'd23: u = mk(A_VEL, B_DT, 6'(TimeFracBits), CAP_MAG, ACT_RES, 2'd0, 1'b0, 1'b0);
			5'd24: u = mk(A_VEL, B_DT, 6'(TimeFracBits), CAP_MAG, ACT_RES, 2'd1, 1'b0, 1'b0);
			5'd25: u = mk(A_VEL, B_DT, 6'(TimeFracBits), CAP_MAG, ACT_RES, 2'd2, 1'b0, 1'b1);
			default: u = mk(A_VEL, B_DT, 6'd0, CAP_MAX, ACT_RES, 2'd0, 1'b0, 1'b1);
		endcase
		return u;
	endfunction

	function automatic logic [63:0] sadd_cov(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, CovCap}) ? CovCap : s[63:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		logic signed [47:0] r;
		if (v > P48Max) r = P48Max[47:0];
		else if (v < P48Min) r = P48Min[47:0];
		else r = v[47:0];
		return r;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > P32Max) r = P32Max[31:0];
		else if (v < P32Min) r = P32Min[31:0];
		else r = v[31:0];
		return r;
	endfunction

endpackage

// File: design/kalman_const_velocity_3d.sv
// Constant-velocity 3-D Kalman tracker built around one shared multiplier and divider.
// Each item yields exactly one result. A measurement that advances time runs predict and
// update as 21 multiply steps (four 32x32 partial products, a shift and saturate step and
// a write-back step each) plus two bit-serial gain divisions. A query ahead of the last
// measurement takes 3 multiply steps; first, ignored or not-ahead items go straight to
// the output. The input is not ready while an item is in progress; a finished result
// waits in the output register and the next item can be taken meanwhile. Writes to the
// position and velocity init std indices are ignored; the covariance reset uses the fixed
// values CovPosRst and CovVelRst.
module kalman_const_velocity_3d (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [167:0] s_tdata,   // timestamp, meas_x, meas_y, meas_z, confidence, zero fill
	input  logic         s_tuser,   // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // out_x, out_y, out_z
	output logic [1:0]   m_tuser,   // result_kind
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MUL   = 7'b0000010,
		S_SHR   = 7'b0000100,
		S_APPLY = 7'b0001000,
		S_DINIT = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [4:0] step_q;
	logic [1:0] ph_q;
	logic [5:0] div_cnt_q;

	logic [15:0] accel_q;
	logic [7:0] smin_q, smax_q;

	logic signed [47:0] pos_q [kcv3d_pkg::Axes];
	logic signed [47:0] vel_q [kcv3d_pkg::Axes];
	logic [63:0] cp_q, cc_q, cv_q;
	logic [47:0] last_q;
	logic started_q;
	logic [1:0] kind_q;

	logic signed [31:0] z_q [kcv3d_pkg::Axes];
	logic signed [63:0] res_q [kcv3d_pkg::Axes];
	logic [23:0] sig_q;
	logic [47:0] dt_q;
	logic [31:0] dts_q;
	logic [63:0] dt2_q, q_q, qdt2_q, np_q, nc_q, s_q, k1_q, k2_q, dv_q;
	logic [127:0] acc_q;
	logic [63:0] p_q, rem_q, dvd_q;
	logic dovf_q, dzero_q;

	logic m_tvalid_q;
	logic [95:0] m_tdata_q;
	logic [1:0] m_tuser_q;

	// input field decode
	logic [47:0] in_ts;
	logic signed [31:0] in_z [kcv3d_pkg::Axes];
	logic [16:0] in_conf, conf_c, conf_inv;
	logic signed [9:0] sig_diff;
	logic signed [27:0] sig_prod, sig_sum;
	logic [47:0] dt_w, dt_sh;
	logic [31:0] dts_w;
	logic ahead;

	assign in_ts = s_tdata[47:0];
	assign in_z[0] = s_tdata[79:48];
	assign in_z[1] = s_tdata[111:80];
	assign in_z[2] = s_tdata[143:112];
	assign in_conf = s_tdata[160:144];
	assign conf_c = (in_conf > 17'd65536) ? 17'd65536 : in_conf;
	assign conf_inv = 17'd65536 - conf_c;
	assign sig_diff = $signed({2'b00, smax_q}) - $signed({2'b00, smin_q});
	assign sig_prod = $signed({1'b0, conf_inv}) * sig_diff;
	assign sig_sum = $signed({4'b0000, smin_q, 16'h0000}) + sig_prod;
	assign dt_w = in_ts - last_q;
	assign dt_sh = dt_w >> kcv3d_pkg::DtsShift;
	assign dts_w = (|dt_sh[47:32]) ? 32'hFFFF_FFFF : dt_sh[31:0];
	assign ahead = in_ts > last_q;

	// operand selection for the shared unit
	kcv3d_pkg::ucode_t uc, uc_nxt;
	logic [4:0] step_nxt;
	logic [1:0] ax;
	logic signed [63:0] vel64, pos64, y64, sp;
	logic [63:0] vel_abs, y_abs, a_op, b_op, capv, pv;
	logic neg;
	logic [31:0] a_half, b_half;
	logic [63:0] pp;
	logic [127:0] pp_sh, acc_nxt, shv;
	logic [64:0] rem2, rem_diff;
	logic [63:0] rem_nxt, quot, dres;
	logic ge;

	assign uc = kcv3d_pkg::ucode(step_q);
	assign step_nxt = step_q + 5'd1;
	assign uc_nxt = kcv3d_pkg::ucode(step_nxt);
	assign ax = uc.axis;
	assign vel64 = {{16{vel_q[ax][47]}}, vel_q[ax]};
	assign pos64 = {{16{pos_q[ax][47]}}, pos_q[ax]};
	assign y64 = {{32{z_q[ax][31]}}, z_q[ax]} - pos64;
	assign vel_abs = vel64[63] ? 64'(-vel64) : 64'(vel64);
	assign y_abs = y64[63] ? 64'(-y64) : 64'(y64);
	assign neg = ((uc.asel == kcv3d_pkg::A_VEL) && vel64[63]) ||
		((uc.asel == kcv3d_pkg::A_Y) && y64[63]);

	always_comb begin
		unique case (uc.asel)
			kcv3d_pkg::A_VEL:  a_op = vel_abs;
			kcv3d_pkg::A_DTS:  a_op = {32'h0, dts_q};
			kcv3d_pkg::A_ACC:  a_op = {48'h0, accel_q};
			kcv3d_pkg::A_Q:    a_op = q_q;
			kcv3d_pkg::A_CC:   a_op = cc_q;
			kcv3d_pkg::A_CV:   a_op = cv_q;
			kcv3d_pkg::A_QDT2: a_op = qdt2_q;
			kcv3d_pkg::A_CP:   a_op = cp_q;
			kcv3d_pkg::A_SIG:  a_op = {40'h0, sig_q};
			kcv3d_pkg::A_Y:    a_op = y_abs;
			default:           a_op = '0;
		endcase
	end

	always_comb begin
		unique case (uc.bsel)
			kcv3d_pkg::B_DT:  b_op = {16'h0, dt_q};
			kcv3d_pkg::B_DTS: b_op = {32'h0, dts_q};
			kcv3d_pkg::B_ACC: b_op = {48'h0, accel_q};
			kcv3d_pkg::B_DT2: b_op = dt2_q;
			kcv3d_pkg::B_K1:  b_op = k1_q;
			kcv3d_pkg::B_K2:  b_op = k2_q;
			kcv3d_pkg::B_SIG: b_op = {40'h0, sig_q};
			default:          b_op = '0;
		endcase
	end

	// one 32x32 partial product per cycle
	assign a_half = ph_q[1] ? a_op[63:32] : a_op[31:0];
	assign b_half = ph_q[0] ? b_op[63:32] : b_op[31:0];
	assign pp = {32'h0, a_half} * {32'h0, b_half};

	always_comb begin
		case (ph_q) inside
			2'd0:       pp_sh = {64'h0, pp};
			2'd1, 2'd2: pp_sh = {32'h0, pp, 32'h0};
			default:    pp_sh = {pp, 64'h0};
		endcase
	end

	assign acc_nxt = ((ph_q == 2'd0) ? 128'h0 : acc_q) + pp_sh;
	assign shv = acc_q >> uc.shift;

	always_comb begin
		unique case (uc.cap)
			kcv3d_pkg::CAP_COV: capv = kcv3d_pkg::CovCap;
			kcv3d_pkg::CAP_MAG: capv = kcv3d_pkg::MagCap;
			default:            capv = kcv3d_pkg::MaxCap;
		endcase
	end

	assign pv = (|shv[127:64]) ? capv : ((shv[63:0] > capv) ? capv : shv[63:0]);
	assign sp = neg ? -$signed(p_q) : $signed(p_q);

	// restoring division, one quotient bit per cycle
	assign rem2 = {rem_q, dvd_q[63]};
	assign rem_diff = rem2 - {1'b0, s_q};
	assign ge = rem2 >= {1'b0, s_q};
	assign rem_nxt = ge ? rem_diff[63:0] : rem2[63:0];
	assign quot = {dvd_q[62:0], ge};
	assign dres = dzero_q ? 64'h0 : (dovf_q ? kcv3d_pkg::MaxCap : quot);

	logic out_free;
	logic signed [63:0] out_v [kcv3d_pkg::Axes];
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		for (int i = 0; i < kcv3d_pkg::Axes; i++) begin
			if (kind_q == kcv3d_pkg::KindNotAhead) out_v[i] = '0;
			else if (kind_q == kcv3d_pkg::KindPredicted) out_v[i] = res_q[i];
			else out_v[i] = {{16{pos_q[i][47]}}, pos_q[i]};
		end
	end

	// control and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			ph_q <= '0;
			div_cnt_q <= '0;
			accel_q <= 16'd300;
			smin_q <= 8'd4;
			smax_q <= 8'd20;
			for (int i = 0; i < kcv3d_pkg::Axes; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
			cp_q <= kcv3d_pkg::CovPosRst;
			cc_q <= '0;
			cv_q <= kcv3d_pkg::CovVelRst;
			last_q <= '0;
			started_q <= 1'b0;
			kind_q <= kcv3d_pkg::KindPredicted;
			m_tvalid_q <= 1'b0;
			m_tuser_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					kcv3d_pkg::CfgAccel:    accel_q <= cfg_data;
					kcv3d_pkg::CfgSigmaMin: smin_q <= cfg_data[7:0];
					kcv3d_pkg::CfgSigmaMax: smax_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if ((state_q == S_OUT) && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						ph_q <= '0;
						if (s_tuser) begin
							if (ahead) begin
								kind_q <= kcv3d_pkg::KindPredicted;
								step_q <= kcv3d_pkg::StepQuery;
								state_q <= S_MUL;
							end else begin
								kind_q <= kcv3d_pkg::KindNotAhead;
								state_q <= S_OUT;
							end
						end else begin
							last_q <= in_ts;
							if (!started_q) begin
								for (int i = 0; i < kcv3d_pkg::Axes; i++)
									pos_q[i] <= {{16{in_z[i][31]}}, in_z[i]};
								started_q <= 1'b1;
								kind_q <= kcv3d_pkg::KindApplied;
								state_q <= S_OUT;
							end else if (ahead) begin
								kind_q <= kcv3d_pkg::KindApplied;
								step_q <= kcv3d_pkg::StepMeas;
								state_q <= S_MUL;
							end else begin
								kind_q <= kcv3d_pkg::KindIgnored;
								state_q <= S_OUT;
							end
						end
					end
				end
				S_MUL: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) state_q <= S_SHR;
				end
				S_SHR: state_q <= S_APPLY;
				S_APPLY: begin
					case (uc.act)
						kcv3d_pkg::ACT_POS: pos_q[ax] <= kcv3d_pkg::sat48(pos64 + sp);
						kcv3d_pkg::ACT_VEL: vel_q[ax] <= kcv3d_pkg::sat48(vel64 + sp);
						kcv3d_pkg::ACT_NCC: begin
							cp_q <= np_q;
							cc_q <= kcv3d_pkg::sadd_cov(nc_q, p_q);
							cv_q <= kcv3d_pkg::sadd_cov(cv_q,
								(qdt2_q > kcv3d_pkg::CovCap) ? kcv3d_pkg::CovCap : qdt2_q);
						end
						kcv3d_pkg::ACT_CP: cp_q <= cp_q - p_q;
						kcv3d_pkg::ACT_CC: begin
							cc_q <= cc_q - p_q;
							cv_q <= (dv_q > cv_q) ? 64'h0 : cv_q - dv_q;
						end
						default: ;
					endcase
					ph_q <= '0;
					if (uc.last) begin
						state_q <= S_OUT;
					end else begin
						step_q <= step_nxt;
						state_q <= uc_nxt.is_div ? S_DINIT : S_MUL;
					end
				end
				S_DINIT: begin
					div_cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd63) begin
						ph_q <= '0;
						step_q <= step_nxt;
						state_q <= uc_nxt.is_div ? S_DINIT : S_MUL;
					end
				end
				S_OUT: begin
					if (out_free) begin
						m_tuser_q <= kind_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath temporaries and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					for (int i = 0; i < kcv3d_pkg::Axes; i++) z_q[i] <= in_z[i];
					sig_q <= sig_sum[23:0];
					dt_q <= dt_w;
					dts_q <= dts_w;
				end
			end
			S_MUL: acc_q <= acc_nxt;
			S_SHR: p_q <= pv;
			S_APPLY: begin
				case (uc.act)
					kcv3d_pkg::ACT_RES:  res_q[ax] <= pos64 + sp;
					kcv3d_pkg::ACT_DT2:  dt2_q <= p_q;
					kcv3d_pkg::ACT_Q:    q_q <= p_q;
					kcv3d_pkg::ACT_QDT2: qdt2_q <= p_q;
					kcv3d_pkg::ACT_NP0:  np_q <= kcv3d_pkg::sadd_cov(cp_q, p_q);
					kcv3d_pkg::ACT_NP:   np_q <= kcv3d_pkg::sadd_cov(np_q, p_q);
					kcv3d_pkg::ACT_NC0:  nc_q <= kcv3d_pkg::sadd_cov(cc_q, p_q);
					kcv3d_pkg::ACT_S:    s_q <= cp_q + p_q;
					kcv3d_pkg::ACT_DV:   dv_q <= p_q;
					default: ;
				endcase
			end
			S_DINIT: begin
				rem_q <= {32'h0, a_op[63:32]};
				dvd_q <= {a_op[31:0], 32'h0};
				dovf_q <= {32'h0, a_op[63:32]} >= s_q;
				dzero_q <= (s_q == 64'h0);
			end
			S_DIV: begin
				rem_q <= rem_nxt;
				dvd_q <= quot;
				if (div_cnt_q == 6'd63) begin
					if (uc.act == kcv3d_pkg::ACT_K1) k1_q <= dres;
					else k2_q <= dres;
				end
			end
			S_OUT: begin
				if (out_free) begin
					m_tdata_q <= {kcv3d_pkg::sat32(out_v[2]), kcv3d_pkg::sat32(out_v[1]),
						kcv3d_pkg::sat32(out_v[0])};
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	a_cov_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(cp_q <= kcv3d_pkg::CovCap) && (cc_q <= kcv3d_pkg::CovCap) &&
		(cv_q <= kcv3d_pkg::CovCap))
		else $error("covariance outside saturation range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item taken while previous item in progress");

	a_not_ahead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == kcv3d_pkg::KindNotAhead) |-> (m_tdata == '0))
		else $error("query not ahead carries nonzero position");

endmodule

// File: bench/tb_kalman_const_velocity_3d.sv
// Self-checking testbench for the constant-velocity 3-D tracker, with its own predictor.
`timescale 1ns / 1ps

module tb_kalman_const_velocity_3d;

	localparam logic OpMeasure = 1'b0;
	localparam logic OpQuery = 1'b1;
	localparam logic [2:0] CfgPosInit = 3'd3;
	localparam logic [2:0] CfgVelInit = 3'd4;
	localparam int CycleLimit = 3000000;

	typedef struct {
		logic              op;
		logic [47:0]       ts;
		logic signed [31:0] pos_meas [3];
		logic [16:0]       conf;
	} meas_item_t;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] coord [3];
	} track_out_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [167:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;

	kalman_const_velocity_3d i_dut (.*);

	always #10 clk = ~clk;

	// tracker state as predicted by the bench
	logic [15:0] trk_accel = 16'd300;
	logic [7:0]  trk_smin = 8'd4;
	logic [7:0]  trk_smax = 8'd20;
	longint      est_pos [3];
	longint      est_vel [3];
	logic [63:0] p_pos, p_cross, p_vel;
	logic [47:0] last_ts;
	logic        have_fix;

	track_out_t  pending_q [$];
	int          errors = 0;
	int          cycles = 0;
	int          tx_gap_max = 18;
	int          rx_stall_max = 18;
	int          rx_hold = 0;

	function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s,
			logic [63:0] cap);
		logic [127:0] p;
		p = ({64'b0, a} * {64'b0, b}) >> s;
		if (p[127:64] != 0) return cap;
		return (p[63:0] > cap) ? cap : p[63:0];
	endfunction

	function automatic longint smul_shr(longint a, logic [63:0] b, int s);
		logic [63:0] mag, m;
		mag = (a < 0) ? -a : a;
		m = mul_shr(mag, b, s, kcv3d_pkg::MagCap);
		return (a < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [63:0] add_cov(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, kcv3d_pkg::CovCap}) ? kcv3d_pkg::CovCap : s[63:0];
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [63:0] gain_q32(logic [63:0] n, logic [63:0] d);
		logic [127:0] t;
		if ((n / d) >> 32 != 0) return kcv3d_pkg::MaxCap;
		t = ({64'b0, n} << 32) / {64'b0, d};
		return t[63:0];
	endfunction

	function automatic longint extrapolate(int ax, logic [63:0] dt);
		return est_pos[ax] + smul_shr(est_vel[ax], dt, kcv3d_pkg::TimeFracBits);
	endfunction

	function automatic void time_update(logic [63:0] dt);
		logic [63:0] dts, dt2, q, qdt2, np, nc, nv;
		dts = dt >> (kcv3d_pkg::TimeFracBits - 16);
		if (dts > 64'hFFFF_FFFF) dts = 64'hFFFF_FFFF;
		for (int ax = 0; ax < 3; ax++)
			est_pos[ax] = clamp(extrapolate(ax, dt), kcv3d_pkg::P48Min, kcv3d_pkg::P48Max);
		dt2 = mul_shr(dts, dts, 16, kcv3d_pkg::MaxCap);
		q = 64'(trk_accel) * 64'(trk_accel);
		qdt2 = mul_shr(q, dt2, 8, kcv3d_pkg::MaxCap);
		np = add_cov(p_pos, mul_shr(p_cross, dts, 15, kcv3d_pkg::CovCap));
		np = add_cov(np, mul_shr(p_vel, dt2, 16, kcv3d_pkg::CovCap));
		np = add_cov(np, mul_shr(qdt2, dt2, 18, kcv3d_pkg::CovCap));
		nc = add_cov(p_cross, mul_shr(p_vel, dts, 16, kcv3d_pkg::CovCap));
		nc = add_cov(nc, mul_shr(qdt2, dts, 17, kcv3d_pkg::CovCap));
		nv = add_cov(p_vel, (qdt2 > kcv3d_pkg::CovCap) ? kcv3d_pkg::CovCap : qdt2);
		p_pos = np;
		p_cross = nc;
		p_vel = nv;
	endfunction

	function automatic void meas_update(meas_item_t it, logic [16:0] conf);
		longint sig, y;
		logic [63:0] sq, r, s, k1, k2, dv;
		k1 = 0;
		k2 = 0;
		sig = longint'(trk_smin) * 65536 +
			(65536 - longint'(conf)) * (longint'(trk_smax) - longint'(trk_smin));
		sq = sig * sig;
		r = sq >> 24;
		s = p_pos + r;
		if (s != 0) begin
			k1 = gain_q32(p_pos, s);
			k2 = gain_q32(p_cross, s);
		end
		for (int ax = 0; ax < 3; ax++) begin
			y = longint'(it.pos_meas[ax]) - est_pos[ax];
			est_pos[ax] = clamp(est_pos[ax] + smul_shr(y, k1, 32),
				kcv3d_pkg::P48Min, kcv3d_pkg::P48Max);
			est_vel[ax] = clamp(est_vel[ax] + smul_shr(y, k2, 32),
				kcv3d_pkg::P48Min, kcv3d_pkg::P48Max);
		end
		dv = mul_shr(p_cross, k2, 32, kcv3d_pkg::CovCap);
		p_pos = p_pos - mul_shr(p_pos, k1, 32, kcv3d_pkg::CovCap);
		p_cross = p_cross - mul_shr(p_cross, k1, 32, kcv3d_pkg::CovCap);
		p_vel = (dv > p_vel) ? 0 : p_vel - dv;
	endfunction

	function automatic track_out_t track_step(meas_item_t it);
		track_out_t o;
		longint res [3];
		logic [16:0] conf;
		logic [47:0] prev;
		conf = (it.conf > 17'd65536) ? 17'd65536 : it.conf;
		for (int ax = 0; ax < 3; ax++) res[ax] = 0;
		if (it.op == OpQuery) begin
			if (it.ts > last_ts) begin
				o.kind = kcv3d_pkg::KindPredicted;
				for (int ax = 0; ax < 3; ax++) res[ax] = extrapolate(ax, 64'(it.ts - last_ts));
			end else begin
				o.kind = kcv3d_pkg::KindNotAhead;
			end
		end else begin
			prev = last_ts;
			last_ts = it.ts;
			o.kind = kcv3d_pkg::KindApplied;
			if (!have_fix) begin
				for (int ax = 0; ax < 3; ax++) est_pos[ax] = it.pos_meas[ax];
				have_fix = 1'b1;
			end else if (it.ts > prev) begin
				time_update(64'(it.ts - prev));
				meas_update(it, conf);
			end else begin
				o.kind = kcv3d_pkg::KindIgnored;
			end
			for (int ax = 0; ax < 3; ax++) res[ax] = est_pos[ax];
		end
		for (int ax = 0; ax < 3; ax++)
			o.coord[ax] = 32'(clamp(res[ax], kcv3d_pkg::P32Min, kcv3d_pkg::P32Max));
		return o;
	endfunction

	// drive one item and record its expected result once taken
	task automatic send_item(meas_item_t it);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser = it.op;
		s_tdata = {7'b0, it.conf, it.pos_meas[2], it.pos_meas[1], it.pos_meas[0], it.ts};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_q.push_back(track_step(it));
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (pending_q.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			kcv3d_pkg::CfgAccel: trk_accel = val;
			kcv3d_pkg::CfgSigmaMin: trk_smin = val[7:0];
			kcv3d_pkg::CfgSigmaMax: trk_smax = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic meas_item_t mk(logic op, logic [47:0] ts, int x, int y, int z,
			logic [16:0] conf);
		meas_item_t it;
		it.op = op;
		it.ts = ts;
		it.pos_meas[0] = x;
		it.pos_meas[1] = y;
		it.pos_meas[2] = z;
		it.conf = conf;
		return it;
	endfunction

	// mostly well-formed tracking steps near the current estimate, some noise
	function automatic meas_item_t random_item();
		meas_item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		it.op = OpMeasure;
		it.conf = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
		for (int ax = 0; ax < 3; ax++)
			it.pos_meas[ax] = 32'(clamp(est_pos[ax] + $urandom_range(0, 16383) - 8192,
				kcv3d_pkg::P32Min, kcv3d_pkg::P32Max));
		if (pick < 70) begin
			it.ts = last_ts + 48'($urandom_range(1, 1 << 18));
		end else if (pick < 85) begin
			it.op = OpQuery;
			it.ts = last_ts + 48'($urandom_range(1, 1 << 21));
		end else if (pick < 90) begin
			it.op = OpQuery;
			it.ts = last_ts - 48'($urandom_range(0, 4096));
		end else if (pick < 94) begin
			it.ts = last_ts - 48'($urandom_range(0, 1 << 20));
		end else begin
			it.op = 1'($urandom);
			it.ts = {16'($urandom), 32'($urandom)};
			for (int ax = 0; ax < 3; ax++) it.pos_meas[ax] = $urandom;
		end
		return it;
	endfunction

	task automatic test_directed();
		send_item(mk(OpQuery, 48'd1000, 0, 0, 0, 17'd0));
		send_item(mk(OpQuery, 48'd0, 1, 2, 3, 17'd0));
		send_item(mk(OpMeasure, 48'd1 << 20, 32'h7FFF_FFFF, 32'sh8000_0000, 1234, 17'd65536));
		send_item(mk(OpMeasure, 48'd1 << 20, 5, 6, 7, 17'd65536));
		send_item(mk(OpMeasure, 48'd3 << 19, 32'h7FFF_F000, -32'sh7FFF_F000, 1000, 17'd0));
		send_item(mk(OpMeasure, 48'd2 << 20, 32'sh8000_0000, 32'h7FFF_FFFF, -500, 17'd65536));
		send_item(mk(OpMeasure, 48'd5 << 19, 0, 0, 0, 17'h1FFFF));
		send_item(mk(OpQuery, 48'd10 << 20, 0, 0, 0, 17'd0));
		send_item(mk(OpQuery, 48'd1 << 20, 0, 0, 0, 17'd0));
		send_item(mk(OpMeasure, 48'd4 << 20, -1, -1, -1, 17'd32768));
		send_item(mk(OpMeasure, 48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 17'd0));
		send_item(mk(OpQuery, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 17'd0));
		send_item(mk(OpMeasure, 48'd100, 0, 0, 0, 17'd65536));
		send_item(mk(OpQuery, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 17'd0));
		send_item(mk(OpMeasure, 48'd200, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 17'd1));
		drain();
	endtask

	// zero noise settings drive the gain to one and the innovation toward singular
	task automatic test_zero_noise();
		write_reg(kcv3d_pkg::CfgAccel, 16'd0);
		write_reg(kcv3d_pkg::CfgSigmaMin, 16'd0);
		write_reg(kcv3d_pkg::CfgSigmaMax, 16'd0);
		write_reg(CfgPosInit, 16'd0);
		write_reg(CfgVelInit, 16'd0);
		for (int i = 1; i <= 6; i++)
			send_item(mk(OpMeasure, last_ts + 48'(i), 256 * i, -256 * i, 7, 17'd65536));
		send_item(mk(OpQuery, last_ts + 48'd1, 0, 0, 0, 17'd0));
		drain();
	endtask

	task automatic test_random(int n);
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(kcv3d_pkg::CfgAccel, 16'hFFFF);
					write_reg(kcv3d_pkg::CfgSigmaMin, 16'hFF);
					write_reg(kcv3d_pkg::CfgSigmaMax, 16'hFF); end
				1: begin write_reg(kcv3d_pkg::CfgSigmaMin, 16'd200);
					write_reg(kcv3d_pkg::CfgSigmaMax, 16'd3); end
				2: begin write_reg(kcv3d_pkg::CfgAccel, 16'd300);
					write_reg(kcv3d_pkg::CfgSigmaMin, 16'd4);
					write_reg(kcv3d_pkg::CfgSigmaMax, 16'd20); end
				default: begin
					write_reg(kcv3d_pkg::CfgAccel, 16'($urandom_range(0, 2000)));
					write_reg(kcv3d_pkg::CfgSigmaMin, 16'($urandom_range(0, 255)));
					write_reg(kcv3d_pkg::CfgSigmaMax, 16'($urandom_range(0, 255)));
					write_reg(CfgPosInit, 16'($urandom));
					write_reg(CfgVelInit, 16'($urandom));
				end
			endcase
			tx_gap_max = (phase == 3) ? 0 : 18;
			rx_stall_max = (phase == 4) ? 0 : 18;
			for (int i = 0; i < n / 6; i++) send_item(random_item());
			drain();
		end
		tx_gap_max = 18;
		rx_stall_max = 18;
	endtask

	// hold the result side off while items keep coming so the input stalls
	task automatic test_backpressure();
		rx_hold = 3000;
		tx_gap_max = 0;
		for (int i = 0; i < 20; i++) send_item(random_item());
		tx_gap_max = 18;
		drain();
	endtask

	task automatic test_pause();
		for (int i = 0; i < 30; i++) send_item(random_item());
		drain();
		for (int i = 0; i < 30; i++) send_item(random_item());
		drain();
	endtask

	always begin
		int stall;
		@(negedge clk);
		if (rx_hold > 0) begin
			m_tready = 1'b0;
			while (rx_hold > 0) begin
				@(negedge clk);
				rx_hold--;
			end
		end
		stall = $urandom_range(0, rx_stall_max);
		m_tready = 1'b0;
		repeat (stall) @(negedge clk);
		m_tready = 1'b1;
		do @(posedge clk); while (!m_tvalid);
	end

	always @(posedge clk) begin
		track_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result kind %0d data %h", $time, m_tuser, m_tdata);
			end else begin
				want = pending_q.pop_front();
				if (m_tuser !== want.kind) begin
					errors++;
					$display("%0t kind expected %0d actual %0d", $time, want.kind, m_tuser);
				end
				for (int ax = 0; ax < 3; ax++)
					if (m_tdata[32*ax +: 32] !== want.coord[ax]) begin
						errors++;
						$display("%0t axis %0d expected %h actual %h", $time, ax,
							want.coord[ax], m_tdata[32*ax +: 32]);
					end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("[kalman_const_velocity_3d] ERROR");
			$finish;
		end
	end

	initial begin
		for (int ax = 0; ax < 3; ax++) begin
			est_pos[ax] = 0;
			est_vel[ax] = 0;
		end
		p_pos = kcv3d_pkg::CovPosRst;
		p_cross = 0;
		p_vel = kcv3d_pkg::CovVelRst;
		last_ts = 0;
		have_fix = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_zero_noise();
		test_backpressure();
		test_pause();
		test_random(1140);
		drain();
		repeat (300) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("[kalman_const_velocity_3d] OK");
		end else begin
			$display("[kalman_const_velocity_3d] ERROR");
		end
		$finish;
	end

endmodule

// File: kalman_const_velocity_3d.f
design/kcv3d_pkg.sv
design/kalman_const_velocity_3d.sv
bench/tb_kalman_const_velocity_3d.sv
